// ----- design/scbp_pkg.sv -----
// Shared types, keyword tables and helper functions for the command byte parser.
`timescale 1ns / 1ps
package scbp_pkg;

   localparam int NKEY     = 30;
   localparam int KEY_BITS = 8 * 16;

   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_FILL = 8'hFF;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_FREQ  = 2'd1;
   localparam logic [1:0] KIND_AMP   = 2'd2;
   localparam logic [1:0] KIND_PHASE = 2'd3;

   localparam logic [1:0] TGT_BOTH  = 2'd0;
   localparam logic [1:0] TGT_SMALL = 2'd1;
   localparam logic [1:0] TGT_LARGE = 2'd2;

   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
   localparam logic [1:0] WAVE_SQUARE   = 2'd2;

   typedef enum logic [4:0] {
      ACT_CH1, ACT_CH2, ACT_CH3, ACT_CH4, ACT_TS, ACT_TL, ACT_TB,
      ACT_FS, ACT_FL, ACT_FC, ACT_AS, ACT_AL, ACT_AC, ACT_PS, ACT_PL, ACT_PC,
      ACT_W0, ACT_W1, ACT_W2, ACT_NOP
   } act_type;

   typedef struct packed {
      logic    found;
      act_type act;
   } match_type;

   // Text is right-justified: the first character sits in the highest used byte.
   localparam logic [KEY_BITS-1:0] KEY_TEXT [NKEY] = '{
      KEY_BITS'("CH1"), KEY_BITS'("CH2"), KEY_BITS'("CH3"), KEY_BITS'("CH4"),
      KEY_BITS'({"AD98", "33"}), KEY_BITS'({"AD99", "59"}),
      KEY_BITS'("BOTH"), KEY_BITS'("ALL"),
      KEY_BITS'({"AD99", "59_FRE"}), KEY_BITS'({"AD99", "59_FREQ"}),
      KEY_BITS'({"AD98", "33_FRE"}), KEY_BITS'({"AD98", "33_FREQ"}),
      KEY_BITS'("FREQ"), KEY_BITS'("FRE"),
      KEY_BITS'({"AD99", "59_AMP"}), KEY_BITS'({"AD98", "33_AMP"}), KEY_BITS'("AMP"),
      KEY_BITS'({"AD99", "59_PHASE"}), KEY_BITS'({"AD99", "59_PHA"}),
      KEY_BITS'({"AD98", "33_PHASE"}), KEY_BITS'("PHASE"),
      KEY_BITS'("SIN"), KEY_BITS'("SINE"), KEY_BITS'("TRIANGLE"), KEY_BITS'("TRI"),
      KEY_BITS'("SQUARE"),
      KEY_BITS'("KEY_VAL 01"), KEY_BITS'("KEY_VAL 02"),
      KEY_BITS'("KEY_VAL 03"), KEY_BITS'("KEY_VAL 04")
   };

   localparam logic [4:0] KEY_LEN [NKEY] = '{
      5'd3, 5'd3, 5'd3, 5'd3, 5'd6, 5'd6, 5'd4, 5'd3,
      5'd10, 5'd11, 5'd10, 5'd11, 5'd4, 5'd3,
      5'd10, 5'd10, 5'd3,
      5'd12, 5'd10, 5'd12, 5'd5,
      5'd3, 5'd4, 5'd8, 5'd3, 5'd6,
      5'd10, 5'd10, 5'd10, 5'd10
   };

   localparam act_type KEY_ACT [NKEY] = '{
      ACT_CH1, ACT_CH2, ACT_CH3, ACT_CH4, ACT_TS, ACT_TL, ACT_TB, ACT_TB,
      ACT_FL, ACT_FL, ACT_FS, ACT_FS, ACT_FC, ACT_FC,
      ACT_AL, ACT_AS, ACT_AC,
      ACT_PL, ACT_PL, ACT_PS, ACT_PC,
      ACT_W0, ACT_W0, ACT_W1, ACT_W1, ACT_W2,
      ACT_NOP, ACT_NOP, ACT_NOP, ACT_NOP
   };

   // Remainder by 100 for values below 16384, by reciprocal multiply.
   function automatic logic [6:0] mod100_small(input logic [13:0] s);
      logic [26:0] p;
      logic [7:0]  q;
      logic [13:0] r;
      p = 27'(s) * 27'(5243);
      q = p[26:19];
      r = s - 14'(q) * 14'(100);
      return r[6:0];
   endfunction

   // Whole degrees from the value taken modulo 100.
   function automatic logic [8:0] phase_of(input logic [6:0] m);
      logic [12:0] v;
      logic [25:0] p;
      v = 13'(m) * 13'(36) + 13'(1800);
      if (v >= 13'(3600)) v = v - 13'(3600);
      p = 26'(v) * 26'(6554);
      return p[24:16];
   endfunction

endpackage

// ----- design/scbp_channels.sv -----
// Handshake channel interfaces for received bytes and parser results.
`timescale 1ns / 1ps
interface scbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface scbp_rsp_if;
   logic        valid;
   logic        ready;
   logic        apply_valid;
   logic [1:0]  apply_target;
   logic [31:0] frequency_hz;
   logic [8:0]  phase_deg;
   logic [7:0]  small_amplitude;
   logic [9:0]  large_amplitude;
   logic [1:0]  wave_shape;
   logic        small_channel;
   logic [1:0]  large_channel;
   logic [31:0] applied_count;
   logic [31:0] fault_count;
   logic [1:0]  awaiting_kind;
   modport source (output valid, output apply_valid, output apply_target,
                   output frequency_hz, output phase_deg, output small_amplitude,
                   output large_amplitude, output wave_shape, output small_channel,
                   output large_channel, output applied_count, output fault_count,
                   output awaiting_kind, input ready);
   modport sink (input valid, input apply_valid, input apply_target,
                 input frequency_hz, input phase_deg, input small_amplitude,
                 input large_amplitude, input wave_shape, input small_channel,
                 input large_channel, input applied_count, input fault_count,
                 input awaiting_kind, output ready);
endinterface

// ----- design/scbp_keyword.sv -----
// Keyword match vector advance and end-of-line keyword lookup.
`timescale 1ns / 1ps
module scbp_keyword
   import scbp_pkg::*;
#(
   parameter int COUNT_W = 6
) (
   input  logic [NKEY-1:0]    hits,
   input  logic               cr_held,
   input  logic [COUNT_W-1:0] line_count,
   input  logic [7:0]         rx_byte,
   output logic [NKEY-1:0]    hits_next,
   output match_type          match
);

   logic [7:0]         upper;
   logic [NKEY-1:0]    base;
   logic [COUNT_W-1:0] len;

   assign upper = (rx_byte >= 8'h61 && rx_byte <= 8'h7A) ? (rx_byte - 8'd32) : rx_byte;
   // A held CR followed by more text kills every keyword.
   assign base  = cr_held ? '0 : hits;
   assign len   = line_count - COUNT_W'(cr_held);

   always_comb begin
      logic [3:0]          sh;
      logic [KEY_BITS-1:0] shifted;
      hits_next = base;
      for (int k = 0; k < NKEY; k++) begin
         sh      = 4'(KEY_LEN[k] - 5'd1 - 5'(line_count));
         shifted = KEY_TEXT[k] >> {sh, 3'b000};
         if (9'(line_count) >= 9'(KEY_LEN[k]) || shifted[7:0] != upper) begin
            hits_next[k] = 1'b0;
         end
      end
   end

   // First full-length match in table order wins.
   always_comb begin
      match.found = 1'b0;
      match.act   = ACT_NOP;
      for (int k = NKEY - 1; k >= 0; k--) begin
         if (hits[k] && 9'(len) == 9'(KEY_LEN[k])) begin
            match.found = 1'b1;
            match.act   = KEY_ACT[k];
         end
      end
   end

endmodule

// ----- design/scbp_scale.sv -----
// Scaling of a received value into frequency, amplitude and phase settings.
`timescale 1ns / 1ps
module scbp_scale
   import scbp_pkg::*;
#(
   parameter int MAX_LARGE_AMPLITUDE = 1023
) (
   input  logic [31:0] raw,
   input  logic [6:0]  raw_mod100,
   output logic [31:0] frequency,
   output logic [7:0]  small_amp,
   output logic [9:0]  large_amp,
   output logic [8:0]  phase
);

   logic [14:0] s_mul;
   logic [27:0] s_div;
   logic [31:0] l_val;

   always_comb begin
      if (raw == 32'd0) frequency = 32'd0;
      else if (raw < 32'd100000) frequency = 32'(raw[16:0]) * 32'd2000;
      else frequency = raw;
   end

   assign s_mul = 15'(raw[6:0]) * 15'd255;
   assign s_div = 28'(s_mul) * 28'd5243;

   always_comb begin
      if (raw <= 32'd10) small_amp = 8'(raw[3:0] * 8'd25);
      else if (raw <= 32'd100) small_amp = s_div[26:19];
      else if (raw > 32'd255) small_amp = 8'd255;
      else small_amp = raw[7:0];
   end

   always_comb begin
      if (raw <= 32'd10) l_val = 32'(raw[3:0]) * 32'd100;
      else if (raw <= 32'd100) l_val = 32'(raw[6:0]) * 32'd10;
      else l_val = raw;
      if (l_val > 32'(MAX_LARGE_AMPLITUDE)) l_val = 32'(MAX_LARGE_AMPLITUDE);
      large_amp = l_val[9:0];
   end

   assign phase = phase_of(raw_mod100);

endmodule

// ----- design/screen_command_byte_parser_unit.sv -----
// Top level of the touch-screen command byte parser.
//   channel  | dir | beat contents
//   req_bus  | in  | rx_byte, one received serial byte
//   rsp_bus  | out | update request flag and target, current settings, counters, pending kind
// One byte enters per cycle unless a stalled result holds the input register; each
// beat is registered first in the input register and then in the result register,
// from which its result beat leaves when it is taken.
// All per-byte work is one pass of keyword compare and value accumulation logic.
// A stalled result holds the pipeline; the input register still takes a byte while it
// is empty or while the result register is empty or being drained.
// Synchronous reset restores defaults at once; there is no clearing pass.
`timescale 1ns / 1ps
module screen_command_byte_parser_unit
   import scbp_pkg::*;
#(
   parameter int LINE_CAPACITY       = 48,
   parameter int MAX_LARGE_AMPLITUDE = 1023
) (
   input logic        clock,
   input logic        reset,
   scbp_req_if.sink   req_bus,
   scbp_rsp_if.source rsp_bus
);

   localparam int COUNT_W = $clog2(LINE_CAPACITY);

   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic advance;

   logic [NKEY-1:0]    hits_ff, hits_in;
   logic               cr_held_ff, cr_held_in;
   logic [COUNT_W-1:0] line_count_ff, line_count_in;
   logic [2:0]         vcount_ff, vcount_in;
   logic [3:0][7:0]    vbytes_ff, vbytes_in;
   logic               cr4_ff, cr4_in;
   logic [6:0]         bin_mod_ff, bin_mod_in;
   logic [16:0]        dec_acc_ff, dec_acc_in;
   logic [6:0]         dec_mod_ff, dec_mod_in;
   logic               dec_ok_ff, dec_ok_in;
   logic               dec_digit_ff, dec_digit_in;
   logic [1:0]         term_ff, term_in;
   logic [1:0]         pend_kind_ff, pend_kind_in;
   logic [1:0]         pend_tgt_ff, pend_tgt_in;
   logic [1:0]         cur_tgt_ff, cur_tgt_in;
   logic [31:0]        freq_ff, freq_in;
   logic [8:0]         phase_ff, phase_in;
   logic [7:0]         samp_ff, samp_in;
   logic [9:0]         lamp_ff, lamp_in;
   logic [1:0]         wave_ff, wave_in;
   logic               sch_ff, sch_in;
   logic [1:0]         lch_ff, lch_in;
   logic [31:0]        applied_ff, applied_in;
   logic [31:0]        fault_ff, fault_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_apply_ff, out_apply_in;
   logic [1:0]  out_tgt_ff, out_tgt_in;

   logic [NKEY-1:0] hits_adv;
   match_type       match;
   logic [31:0]     raw;
   logic [6:0]      raw_mod;
   logic            use_bin;
   logic [31:0]     sc_freq;
   logic [7:0]      sc_samp;
   logic [9:0]      sc_lamp;
   logic [8:0]      sc_phase;

   scbp_keyword #(.COUNT_W(COUNT_W)) u_keyword (
      .hits       (hits_ff),
      .cr_held    (cr_held_ff),
      .line_count (line_count_ff),
      .rx_byte    (in_byte_ff),
      .hits_next  (hits_adv),
      .match      (match)
   );

   assign raw     = use_bin ? vbytes_ff : 32'(dec_acc_ff);
   assign raw_mod = use_bin ? bin_mod_ff : dec_mod_ff;

   scbp_scale #(.MAX_LARGE_AMPLITUDE(MAX_LARGE_AMPLITUDE)) u_scale (
      .raw        (raw),
      .raw_mod100 (raw_mod),
      .frequency  (sc_freq),
      .small_amp  (sc_samp),
      .large_amp  (sc_lamp),
      .phase      (sc_phase)
   );

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || !out_valid_ff || rsp_bus.ready;

   always_comb begin
      if (req_bus.valid && req_bus.ready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_bus.ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_comb begin
      logic [7:0]  b;
      logic [2:0]  cnt_new;
      logic        first;
      logic [6:0]  p_bm;
      logic [16:0] p_acc;
      logic [6:0]  p_mod;
      logic        p_ok, p_digit;
      logic [3:0]  d;
      logic [13:0] s;
      logic        do_apply, do_fault, do_req;
      logic [1:0]  req_tgt;
      logic [COUNT_W-1:0] len;

      b        = in_byte_ff;
      do_apply = 1'b0;
      do_fault = 1'b0;
      do_req   = 1'b0;
      req_tgt  = TGT_BOTH;
      use_bin  = 1'b0;
      len      = line_count_ff - COUNT_W'(cr_held_ff);

      hits_in       = hits_ff;
      cr_held_in    = cr_held_ff;
      line_count_in = line_count_ff;
      vcount_in     = vcount_ff;
      vbytes_in     = vbytes_ff;
      cr4_in        = cr4_ff;
      bin_mod_in    = bin_mod_ff;
      dec_acc_in    = dec_acc_ff;
      dec_mod_in    = dec_mod_ff;
      dec_ok_in     = dec_ok_ff;
      dec_digit_in  = dec_digit_ff;
      term_in       = term_ff;
      pend_kind_in  = pend_kind_ff;
      pend_tgt_in   = pend_tgt_ff;
      cur_tgt_in    = cur_tgt_ff;
      freq_in       = freq_ff;
      phase_in      = phase_ff;
      samp_in       = samp_ff;
      lamp_in       = lamp_ff;
      wave_in       = wave_ff;
      sch_in        = sch_ff;
      lch_in        = lch_ff;
      applied_in    = applied_ff;
      fault_in      = fault_ff;

      cnt_new = vcount_ff + 3'd1;
      first   = (vcount_ff == 3'd0);
      p_bm    = first ? 7'd0 : bin_mod_ff;
      p_acc   = first ? 17'd0 : dec_acc_ff;
      p_mod   = first ? 7'd0 : dec_mod_ff;
      p_ok    = first ? 1'b1 : dec_ok_ff;
      p_digit = first ? 1'b0 : dec_digit_ff;
      d       = b[3:0];
      s       = 14'(p_bm);

      if (b == CHAR_FILL) begin
         // Third fill byte in a row drops line and value buffers.
         if (term_ff == 2'd2) begin
            term_in       = 2'd0;
            hits_in       = '1;
            cr_held_in    = 1'b0;
            line_count_in = '0;
            vcount_in     = 3'd0;
         end else begin
            term_in = term_ff + 2'd1;
         end
      end else begin
         term_in = 2'd0;
         if (pend_kind_ff != KIND_NONE) begin
            vcount_in = cnt_new;
            case (vcount_ff)
               3'd0: s = 14'(p_bm) + 14'(b);
               3'd1: s = 14'(p_bm) + 14'(b) * 14'd56;
               3'd2: s = 14'(p_bm) + 14'(b) * 14'd36;
               3'd3: s = 14'(p_bm) + 14'(b) * 14'd16;
               default: s = 14'(p_bm);
            endcase
            if (vcount_ff < 3'd4) begin
               vbytes_in[vcount_ff[1:0]] = b;
               bin_mod_in = mod100_small(s);
            end
            if (vcount_ff == 3'd4) cr4_in = (b == CHAR_CR);
            // Decimal accumulator tracks the text seen so far.
            dec_acc_in   = p_acc;
            dec_mod_in   = p_mod;
            dec_ok_in    = p_ok;
            dec_digit_in = p_digit;
            if (b != CHAR_CR) begin
               if (b >= 8'h30 && b <= 8'h39) begin
                  dec_acc_in   = 17'(p_acc * 17'd10) + 17'(d);
                  dec_mod_in   = mod100_small(14'(p_mod) * 14'd10 + 14'(d));
                  dec_digit_in = 1'b1;
               end else begin
                  dec_ok_in = 1'b0;
               end
            end
            if (vcount_ff == 3'd5 && cr4_ff && b == CHAR_LF) begin
               do_apply = 1'b1;
               use_bin  = 1'b1;
            end else if (b == CHAR_LF) begin
               if (p_ok && p_digit) do_apply = 1'b1;
               else if (cnt_new == 3'd6) do_fault = 1'b1;
            end else if (cnt_new == 3'd6) begin
               do_fault = 1'b1;
            end
         end else begin
            if (b == CHAR_LF) begin
               if (len != '0) begin
                  if (match.found) begin
                     case (match.act)
                        ACT_CH1, ACT_CH2: begin
                           if (cur_tgt_ff == TGT_SMALL) begin
                              sch_in = (match.act == ACT_CH2);
                           end else begin
                              lch_in = (match.act == ACT_CH2) ? 2'd1 : 2'd0;
                              if (cur_tgt_ff == TGT_BOTH) sch_in = (match.act == ACT_CH2);
                           end
                        end
                        ACT_CH3: lch_in = 2'd2;
                        ACT_CH4: lch_in = 2'd3;
                        ACT_TS:  cur_tgt_in = TGT_SMALL;
                        ACT_TL:  cur_tgt_in = TGT_LARGE;
                        ACT_TB:  cur_tgt_in = TGT_BOTH;
                        ACT_FS, ACT_FL, ACT_FC, ACT_AS, ACT_AL, ACT_AC,
                        ACT_PS, ACT_PL, ACT_PC: begin
                           if (match.act == ACT_FS || match.act == ACT_FL ||
                               match.act == ACT_FC) begin
                              pend_kind_in = KIND_FREQ;
                           end else if (match.act == ACT_AS || match.act == ACT_AL ||
                                        match.act == ACT_AC) begin
                              pend_kind_in = KIND_AMP;
                           end else begin
                              pend_kind_in = KIND_PHASE;
                           end
                           if (match.act == ACT_FS || match.act == ACT_AS ||
                               match.act == ACT_PS) begin
                              pend_tgt_in = TGT_SMALL;
                           end else if (match.act == ACT_FL || match.act == ACT_AL ||
                                        match.act == ACT_PL) begin
                              pend_tgt_in = TGT_LARGE;
                           end else begin
                              pend_tgt_in = cur_tgt_ff;
                           end
                           cur_tgt_in = pend_tgt_in;
                           vcount_in  = 3'd0;
                        end
                        ACT_W0: begin wave_in = WAVE_SINE; do_req = 1'b1; req_tgt = TGT_SMALL; end
                        ACT_W1: begin
                           wave_in = WAVE_TRIANGLE;
                           do_req  = 1'b1;
                           req_tgt = TGT_SMALL;
                        end
                        ACT_W2: begin wave_in = WAVE_SQUARE; do_req = 1'b1; req_tgt = TGT_SMALL; end
                        default: ;
                     endcase
                  end else begin
                     fault_in = fault_ff + 32'd1;
                  end
               end
               hits_in       = '1;
               cr_held_in    = 1'b0;
               line_count_in = '0;
            end else if (line_count_ff < COUNT_W'(LINE_CAPACITY - 1)) begin
               if (b == CHAR_CR) begin
                  hits_in    = cr_held_ff ? '0 : hits_ff;
                  cr_held_in = 1'b1;
               end else begin
                  hits_in    = hits_adv;
                  cr_held_in = 1'b0;
               end
               line_count_in = line_count_ff + COUNT_W'(1);
            end else begin
               // Overflow: drop the byte and start a fresh line.
               fault_in      = fault_ff + 32'd1;
               hits_in       = '1;
               cr_held_in    = 1'b0;
               line_count_in = '0;
            end
         end
      end

      if (do_apply) begin
         case (pend_kind_ff)
            KIND_FREQ: freq_in = sc_freq;
            KIND_AMP: begin
               samp_in = sc_samp;
               lamp_in = sc_lamp;
            end
            default: phase_in = sc_phase;
         endcase
         do_req       = 1'b1;
         req_tgt      = pend_tgt_ff;
         pend_kind_in = KIND_NONE;
         vcount_in    = 3'd0;
      end
      if (do_fault) begin
         fault_in     = fault_ff + 32'd1;
         pend_kind_in = KIND_NONE;
         vcount_in    = 3'd0;
      end
      if (do_req) applied_in = applied_ff + 32'd1;

      out_apply_in = do_req;
      out_tgt_in   = do_req ? req_tgt : TGT_BOTH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         hits_ff       <= '1;
         cr_held_ff    <= 1'b0;
         line_count_ff <= '0;
         vcount_ff     <= 3'd0;
         term_ff       <= 2'd0;
         pend_kind_ff  <= KIND_NONE;
         pend_tgt_ff   <= TGT_BOTH;
         cur_tgt_ff    <= TGT_BOTH;
         freq_ff       <= 32'd1000;
         phase_ff      <= 9'd0;
         samp_ff       <= 8'd128;
         lamp_ff       <= 10'(MAX_LARGE_AMPLITUDE);
         wave_ff       <= WAVE_SINE;
         sch_ff        <= 1'b0;
         lch_ff        <= 2'd0;
         applied_ff    <= 32'd0;
         fault_ff      <= 32'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            hits_ff       <= hits_in;
            cr_held_ff    <= cr_held_in;
            line_count_ff <= line_count_in;
            vcount_ff     <= vcount_in;
            term_ff       <= term_in;
            pend_kind_ff  <= pend_kind_in;
            pend_tgt_ff   <= pend_tgt_in;
            cur_tgt_ff    <= cur_tgt_in;
            freq_ff       <= freq_in;
            phase_ff      <= phase_in;
            samp_ff       <= samp_in;
            lamp_ff       <= lamp_in;
            wave_ff       <= wave_in;
            sch_ff        <= sch_in;
            lch_ff        <= lch_in;
            applied_ff    <= applied_in;
            fault_ff      <= fault_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) in_byte_ff <= req_bus.rx_byte;
      if (advance) begin
         vbytes_ff    <= vbytes_in;
         cr4_ff       <= cr4_in;
         bin_mod_ff   <= bin_mod_in;
         dec_acc_ff   <= dec_acc_in;
         dec_mod_ff   <= dec_mod_in;
         dec_ok_ff    <= dec_ok_in;
         dec_digit_ff <= dec_digit_in;
         out_apply_ff <= out_apply_in;
         out_tgt_ff   <= out_tgt_in;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.apply_valid     = out_apply_ff;
   assign rsp_bus.apply_target    = out_tgt_ff;
   assign rsp_bus.frequency_hz    = freq_ff;
   assign rsp_bus.phase_deg       = phase_ff;
   assign rsp_bus.small_amplitude = samp_ff;
   assign rsp_bus.large_amplitude = lamp_ff;
   assign rsp_bus.wave_shape      = wave_ff;
   assign rsp_bus.small_channel   = sch_ff;
   assign rsp_bus.large_channel   = lch_ff;
   assign rsp_bus.applied_count   = applied_ff;
   assign rsp_bus.fault_count     = fault_ff;
   assign rsp_bus.awaiting_kind   = pend_kind_ff;

endmodule

// ----- design/scbp_checker.sv -----
// Port-level assertions for the command byte parser, bound to the top level.
`timescale 1ns / 1ps
module scbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        apply_valid,
   input logic [1:0]  apply_target,
   input logic [31:0] applied_count
);

   // Stalled beat holds its counter value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(applied_count))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_target_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !apply_valid |-> apply_target == 2'd0)
      else $error("target set without update request");

   a_target_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && apply_valid |-> apply_target != 2'd3)
      else $error("update request with unused target code");

endmodule

bind screen_command_byte_parser_unit scbp_checker u_scbp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .apply_valid   (rsp_bus.apply_valid),
   .apply_target  (rsp_bus.apply_target),
   .applied_count (rsp_bus.applied_count)
);
